### hdl/wss_pkg.sv
// ---------------------------------------------------------------------------
// wss_pkg
// Shared field widths, register indexes, action codes and sequencer states
// for the windowed sample statistics block.
// ---------------------------------------------------------------------------
package wss_pkg;

  localparam int unsigned SampleW = 20;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned LevelW  = 9;
  localparam int unsigned CfgIdxW = 8;

  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 112;

  localparam logic [CfgIdxW-1:0] RegAcceptLow  = 8'd0;
  localparam logic [CfgIdxW-1:0] RegAcceptHigh = 8'd1;

  localparam logic [SampleW-1:0] AcceptLowReset  = 20'd100;
  localparam logic [SampleW-1:0] AcceptHighReset = 20'd500000;

  typedef enum logic {
    ActPush = 1'b0,
    ActRead = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    StIdle,
    StRdOld,
    StWrite,
    StElem,
    StElemCap,
    StScan,
    StScanLast,
    StDiv,
    StDone
  } state_e;

endpackage

### hdl/windowed_sample_statistics.sv
// ---------------------------------------------------------------------------
// windowed_sample_statistics
// Circular sample history with range-gated push, indexed read and
// min / max / average / newest statistics over the filled window.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis beat: tuser = action (0 push, 1 read), tdata = sample, index.
//   A push stores the sample when accept_low < sample < accept_high; once
//   the window is full the oldest entry is overwritten.
//   m_axis beat: one per input beat, tuser = accepted, tdata = fill level,
//   min, max, truncated average, newest sample and the read element.
//   cfg channel writes accept_low (index 0) or accept_high (index 1); it is
//   always ready and is meant to be written while the block is idle.
// Operation:
//   one item at a time: a stored push first reads the oldest entry and writes
//   the new one, an indexed read first fetches its element; then the scan
//   reads one history entry a cycle through the single read port of the
//   history ram, and a restoring divider retires one quotient bit a cycle.
// Reset clears the pointers, fill count and sum; the history ram is not
// cleared. A finished result waits in the output register while the next
// beat is accepted; the sequencer holds before its final step until the
// output register is free, so a stalled receiver loses nothing.
// ---------------------------------------------------------------------------
module windowed_sample_statistics
  import wss_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beat
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // sample[19:0], index[27:20], zero pad
  input  logic                s_axis_tuser,  // action[0]
  // result beat
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // fill_level[8:0], window_min[28:9],
                                             // window_max[48:29], window_avg[68:49],
                                             // newest[88:69], element[108:89], pad
  output logic                m_axis_tuser,  // accepted[0]
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [SampleW-1:0]  cfg_data_i
);

  localparam int unsigned PW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SW  = SampleW + CW;
  localparam int unsigned AW  = ((CW > IndexW) ? CW : IndexW) + 1;
  localparam int unsigned DCW = $clog2(SW);

  localparam logic [PW-1:0] LastSlot = PW'(WINDOW_DEPTH - 1);
  localparam logic [CW-1:0] FullCnt  = CW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] DepthA   = AW'(WINDOW_DEPTH);

  state_e state_q, state_d;

  logic [SampleW-1:0] acc_low_q, acc_high_q;

  logic [SampleW-1:0] hist_mem [WINDOW_DEPTH];
  logic [SampleW-1:0] rdata_q;
  logic               mem_we, mem_re;
  logic [PW-1:0]      mem_raddr;

  logic [PW-1:0]      wp_q, head_q;
  logic [CW-1:0]      fill_q;
  logic [SW-1:0]      sum_q;
  logic [SampleW-1:0] newest_q;

  logic               action_q;
  logic [SampleW-1:0] sample_q;
  logic [IndexW-1:0]  index_q;
  logic               accepted_q;
  logic [SampleW-1:0] element_q;
  logic [SampleW-1:0] min_q, max_q;
  logic [CW-1:0]      scan_q;
  logic               pend_q;

  logic [CW:0]        rem_q;
  logic [SW-1:0]      dq_q;
  logic [DCW-1:0]     dcnt_q;

  logic               m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic               m_user_q;

  logic               s_fire, out_free, full, store_ok, idx_hit, scan_end;
  logic [SampleW-1:0] in_sample;
  logic [IndexW-1:0]  in_index;
  logic [AW-1:0]      pos, slot_sum, slot_wrap;
  logic [CW+1:0]      trial, trial_sub;
  logic               empty;

  assign in_sample = s_axis_tdata[SampleW-1:0];
  assign in_index  = s_axis_tdata[SampleW+IndexW-1:SampleW];

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign full     = (fill_q == FullCnt);
  assign empty    = (fill_q == '0);
  assign store_ok = (action_e'(s_axis_tuser) == ActPush) &&
                    (in_sample > acc_low_q) && (in_sample < acc_high_q);
  assign idx_hit  = (AW'(index_q) < AW'(fill_q));
  assign scan_end = (scan_q == fill_q - CW'(1));

  // oldest-relative position to physical slot, one wrap at most
  assign pos       = (state_q == StElem) ? AW'(index_q) : AW'(scan_q);
  assign slot_sum  = AW'(head_q) + pos;
  assign slot_wrap = (slot_sum >= DepthA) ? slot_sum - DepthA : slot_sum;

  // restoring divider step
  assign trial     = {rem_q, dq_q[SW-1]};
  assign trial_sub = trial - (CW+2)'(fill_q);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_low_q  <= AcceptLowReset;
      acc_high_q <= AcceptHighReset;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegAcceptLow) begin
        acc_low_q <= cfg_data_i;
      end else if (cfg_index_i == RegAcceptHigh) begin
        acc_high_q <= cfg_data_i;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (s_fire) begin
          if (store_ok) begin
            state_d = StRdOld;
          end else if ((action_e'(s_axis_tuser) == ActRead) &&
                       (AW'(in_index) < AW'(fill_q))) begin
            state_d = StElem;
          end else if (!empty) begin
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end
      end
      StRdOld:    state_d = StWrite;
      StWrite:    state_d = StScan;
      StElem:     state_d = StElemCap;
      StElemCap:  state_d = StScan;
      StScan:     state_d = scan_end ? StScanLast : StScan;
      StScanLast: state_d = StDiv;
      StDiv:      state_d = (dcnt_q == '0) ? StDone : StDiv;
      StDone:     state_d = out_free ? StIdle : StDone;
      default:    state_d = StIdle;
    endcase
  end

  // memory control and handshake
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_raddr     = slot_wrap[PW-1:0];
    unique case (state_q)
      StIdle:  s_axis_tready = 1'b1;
      StRdOld: begin
        mem_re    = 1'b1;
        mem_raddr = wp_q;
      end
      StWrite: mem_we = 1'b1;
      StElem:  mem_re = 1'b1;
      StScan:  mem_re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hist_mem[wp_q] <= sample_q;
    end
    if (mem_re) begin
      rdata_q <= hist_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      wp_q    <= '0;
      head_q  <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == StScan);
      if (state_q == StWrite) begin
        sum_q    <= sum_q - (full ? SW'(rdata_q) : '0) + SW'(sample_q);
        wp_q     <= (wp_q == LastSlot) ? '0 : wp_q + PW'(1);
        if (full) begin
          head_q <= (head_q == LastSlot) ? '0 : head_q + PW'(1);
        end else begin
          fill_q <= fill_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_fire) begin
      action_q   <= s_axis_tuser;
      sample_q   <= in_sample;
      index_q    <= in_index;
      accepted_q <= store_ok;
      element_q  <= '0;
      min_q      <= '1;
      max_q      <= '0;
      scan_q     <= '0;
    end
    if (state_q == StWrite) begin
      newest_q <= sample_q;
    end
    if (state_q == StElemCap && action_e'(action_q) == ActRead && idx_hit) begin
      element_q <= rdata_q;
    end
    if (state_q == StScan) begin
      scan_q <= scan_q + CW'(1);
    end
    if (pend_q) begin
      if (rdata_q < min_q) min_q <= rdata_q;
      if (rdata_q > max_q) max_q <= rdata_q;
    end
    if (state_q == StScanLast) begin
      rem_q  <= '0;
      dq_q   <= sum_q;
      dcnt_q <= DCW'(SW - 1);
    end
    if (state_q == StDiv) begin
      dcnt_q <= dcnt_q - DCW'(1);
      if (!trial_sub[CW+1]) begin
        rem_q <= trial_sub[CW:0];
        dq_q  <= {dq_q[SW-2:0], 1'b1};
      end else begin
        rem_q <= trial[CW:0];
        dq_q  <= {dq_q[SW-2:0], 1'b0};
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == StDone && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StDone && out_free) begin
      m_user_q <= accepted_q;
      m_data_q <= OutDataW'({element_q,
                             empty ? SampleW'(0) : newest_q,
                             empty ? SampleW'(0) : dq_q[SampleW-1:0],
                             empty ? SampleW'(0) : max_q,
                             empty ? SampleW'(0) : min_q,
                             LevelW'(fill_q)});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
